@@ rtl/core/sqvb_pkg.sv @@
// ----------------------------------------------------------------------------
// sqvb_pkg
// Shared types and constants for the sprite quad vertex batcher.
// ----------------------------------------------------------------------------
package sqvb_pkg;

    localparam int VERTS_PER_QUAD = 6;
    localparam int VIDX_W         = $clog2(VERTS_PER_QUAD);

    localparam int POS_W    = 24;
    localparam int SIZE_W   = 23;
    localparam int UV_W     = 16;
    localparam int ANG_W    = 16;
    localparam int TEX_W    = 16;
    localparam int RGBA_W   = 32;

    // corners at doubled scale: 2x +/- 2w spans 26 signed bits
    localparam int CORNER_W = POS_W + 2;
    // sine/cosine in signed Q1.15, +/-1.0 inclusive
    localparam int TRIG_W   = 17;
    localparam int MAG_W    = 16;
    localparam int PROD_W   = CORNER_W + TRIG_W;
    localparam int SUM_W    = PROD_W + 1;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic                      op;
        logic signed [POS_W-1:0]   rect_x;
        logic signed [POS_W-1:0]   rect_y;
        logic [SIZE_W-1:0]         rect_w;
        logic [SIZE_W-1:0]         rect_h;
        logic [UV_W-1:0]           tex_u;
        logic [UV_W-1:0]           tex_v;
        logic [UV_W-1:0]           tex_w;
        logic [UV_W-1:0]           tex_h;
        logic [ANG_W-1:0]          turn;
        logic [TEX_W-1:0]          texture_id;
        logic [RGBA_W-1:0]         rgba;
    } sprite_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   vert_x;
        logic signed [POS_W-1:0]   vert_y;
        logic [UV_W-1:0]           vert_u;
        logic [UV_W-1:0]           vert_v;
        logic [RGBA_W-1:0]         vert_rgba;
        logic [TEX_W-1:0]          vert_texture;
        logic                      group_start;
        logic                      last;
    } vert_t;

    // one vertex handed from the sprite register to the rotate pipe
    typedef struct packed {
        logic signed [CORNER_W-1:0] x;
        logic signed [CORNER_W-1:0] y;
        logic signed [TRIG_W-1:0]   sin;
        logic signed [TRIG_W-1:0]   cos;
        logic [UV_W-1:0]            u;
        logic [UV_W-1:0]            v;
        logic [RGBA_W-1:0]          rgba;
        logic [TEX_W-1:0]           tex;
        logic                       group_start;
        logic                       last;
    } issue_t;

endpackage

@@ rtl/core/sqvb_sine_rom.sv @@
// ----------------------------------------------------------------------------
// sqvb_sine_rom
// Quarter-wave sine table and quadrant folding: angle in, sine and cosine out.
// ----------------------------------------------------------------------------
module sqvb_sine_rom
    import sqvb_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic [ANG_W-1:0]         turn,
    output logic signed [TRIG_W-1:0] sin,
    output logic signed [TRIG_W-1:0] cos
);

    localparam int PW     = $clog2(4 * DEPTH);
    localparam int AW     = $clog2(DEPTH);
    localparam int TAB_W  = MAG_W - 1;
    localparam int PROD_P = ANG_W + 16;

    logic [TAB_W-1:0]          rom [DEPTH];
    logic [PROD_P-1:0]         phase_prod;
    logic [PW-1:0]             phase;
    logic [1:0]                quad;
    logic [AW-1:0]             rem;
    logic [AW-1:0]             rem_mirror;
    logic [MAG_W-1:0]          mag_fwd;
    logic [MAG_W-1:0]          mag_rev;
    logic signed [TRIG_W-1:0]  val_fwd;
    logic signed [TRIG_W-1:0]  val_rev;

    // build each entry from a truncated Taylor series at elaboration
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_tab
        localparam longint unsigned X  = (longint'(i) * HALF_PI_Q30) / DEPTH;
        localparam longint unsigned X2 = (X * X) >> 30;
        localparam longint unsigned T1 = ((X  * X2) >> 30) / 6;
        localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
        localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
        localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
        localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
        localparam longint unsigned S  = X - T1 + T2 - T3 + T4 - T5;
        localparam longint unsigned R  = (S + 64'd16384) >> 15;
        localparam longint unsigned V  = (R > 64'd32767) ? 64'd32767 : R;
        assign rom[i] = TAB_W'(V);
    end

    assign phase_prod = PROD_P'(turn) * PROD_P'(4 * DEPTH);
    assign phase      = PW'(phase_prod >> 16);

    always_comb
    begin
        if (phase >= PW'(3 * DEPTH))
        begin
            quad = 2'd3;
            rem  = AW'(phase - PW'(3 * DEPTH));
        end
        else if (phase >= PW'(2 * DEPTH))
        begin
            quad = 2'd2;
            rem  = AW'(phase - PW'(2 * DEPTH));
        end
        else if (phase >= PW'(DEPTH))
        begin
            quad = 2'd1;
            rem  = AW'(phase - PW'(DEPTH));
        end
        else
        begin
            quad = 2'd0;
            rem  = AW'(phase);
        end
    end

    // mirrored index DEPTH - rem; rem of zero lands on the quarter point (1.0)
    assign rem_mirror = AW'((AW + 1)'(DEPTH) - (AW + 1)'(rem));
    assign mag_fwd    = MAG_W'(rom[rem]);
    assign mag_rev    = (rem == '0) ? MAG_W'(32768) : MAG_W'(rom[rem_mirror]);
    assign val_fwd    = signed'({1'b0, mag_fwd});
    assign val_rev    = signed'({1'b0, mag_rev});

    // sine: odd quadrants read mirrored, upper half negated;
    // cosine is the sine one quadrant later
    assign sin = quad[0] ? (quad[1] ? -val_rev : val_rev)
                         : (quad[1] ? -val_fwd : val_fwd);
    assign cos = quad[0] ? ((quad[1] ^ quad[0]) ? -val_fwd : val_fwd)
                         : ((quad[1] ^ quad[0]) ? -val_rev : val_rev);

endmodule

@@ rtl/core/sqvb_vertex_pipe.sv @@
// ----------------------------------------------------------------------------
// sqvb_vertex_pipe
// Rotate one corner per cycle while the output is not stalled: product register, then round/saturate output.
// ----------------------------------------------------------------------------
module sqvb_vertex_pipe
    import sqvb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   issue_valid,
    input  issue_t issue,
    output logic   advance,
    output logic   vert_valid,
    input  logic   vert_ready,
    output vert_t  vert
);

    localparam int SH_W = SUM_W - 16;

    logic                       prod_valid_reg;
    logic signed [PROD_W-1:0]   xc_reg;
    logic signed [PROD_W-1:0]   ys_reg;
    logic signed [PROD_W-1:0]   xs_reg;
    logic signed [PROD_W-1:0]   yc_reg;
    issue_t                     meta_reg;
    logic                       out_valid_reg;
    vert_t                      vert_reg;
    vert_t                      vert_next;
    logic signed [SUM_W-1:0]    x_sum;
    logic signed [SUM_W-1:0]    y_sum;

    function automatic logic signed [POS_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        logic signed [SH_W-1:0]  sh;
        t  = v + SUM_W'(32768);
        sh = SH_W'(t >>> 16);
        if (sh > SH_W'((2 ** (POS_W - 1)) - 1))
            return POS_W'((2 ** (POS_W - 1)) - 1);
        else if (sh < -SH_W'(2 ** (POS_W - 1)))
            return POS_W'(-(2 ** (POS_W - 1)));
        else
            return POS_W'(sh);
    endfunction

    assign advance    = !out_valid_reg || vert_ready;
    assign vert_valid = out_valid_reg;
    assign vert       = vert_reg;

    assign x_sum = SUM_W'(xc_reg) - SUM_W'(ys_reg);
    assign y_sum = SUM_W'(xs_reg) + SUM_W'(yc_reg);

    always_comb
    begin
        vert_next.vert_x       = round_sat(x_sum);
        vert_next.vert_y       = round_sat(y_sum);
        vert_next.vert_u       = meta_reg.u;
        vert_next.vert_v       = meta_reg.v;
        vert_next.vert_rgba    = meta_reg.rgba;
        vert_next.vert_texture = meta_reg.tex;
        vert_next.group_start  = meta_reg.group_start;
        vert_next.last         = meta_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            prod_valid_reg <= issue_valid;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xc_reg   <= PROD_W'(issue.x) * PROD_W'(issue.cos);
            ys_reg   <= PROD_W'(issue.y) * PROD_W'(issue.sin);
            xs_reg   <= PROD_W'(issue.x) * PROD_W'(issue.sin);
            yc_reg   <= PROD_W'(issue.y) * PROD_W'(issue.cos);
            meta_reg <= issue;
            vert_reg <= vert_next;
        end
    end

endmodule

@@ rtl/core/sprite_quad_vertex_batcher.sv @@
// ----------------------------------------------------------------------------
// sprite_quad_vertex_batcher
// Sprite in, six rotated, textured vertices out as a triangle list.
// ----------------------------------------------------------------------------
// Each accepted sprite request yields six vertex requests in the order TL, BL,
// BR, BR, TR, TL, one per cycle while the output is not stalled, so a steady
// stream runs at one sprite per six vertices; that rate is set by the single
// rotate pipe, which handles one corner per cycle. The next sprite is taken
// in the same cycle that the sixth vertex of the current one leaves the
// sprite register, so there is no bubble between sprites. The first vertex of
// a sprite passes through the sprite register, the product register and the
// output register before it reaches the output. Corners are rotated
// about the coordinate origin, not about the sprite. Sine and cosine come from
// a quarter-wave table of SINE_TABLE_DEPTH entries that is fixed at
// elaboration; the angle is truncated to 4 * SINE_TABLE_DEPTH steps per turn.
// Positions are rounded half up and saturated to Q16.8, UV sums saturate at
// the top of the Q2.14 range. group_start is set on the first vertex of the
// first sprite after reset and whenever the texture id changes from the
// previous sprite; sprites are expected in draw order.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_batcher
    import sqvb_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sprite_valid,
    output logic    sprite_ready,
    input  sprite_t sprite,
    output logic    vert_valid,
    input  logic    vert_ready,
    output vert_t   vert
);

    typedef enum logic [1:0]
    {
        CORNER_TL,
        CORNER_BL,
        CORNER_BR,
        CORNER_TR
    } corner_t;

    localparam logic [VIDX_W-1:0] VIDX_LAST = VIDX_W'(VERTS_PER_QUAD - 1);

    // sprite register: one sprite with its corners and trig already formed
    logic                        spr_valid_reg;
    logic [VIDX_W-1:0]           vidx_reg;
    logic signed [CORNER_W-1:0]  left_reg;
    logic signed [CORNER_W-1:0]  right_reg;
    logic signed [CORNER_W-1:0]  bottom_reg;
    logic signed [CORNER_W-1:0]  top_reg;
    logic signed [TRIG_W-1:0]    sin_reg;
    logic signed [TRIG_W-1:0]    cos_reg;
    logic [UV_W-1:0]             u_l_reg;
    logic [UV_W-1:0]             u_r_reg;
    logic [UV_W-1:0]             v_b_reg;
    logic [UV_W-1:0]             v_t_reg;
    logic [RGBA_W-1:0]           rgba_reg;
    logic [TEX_W-1:0]            tex_reg;
    logic                        start_reg;
    logic [TEX_W-1:0]            prev_tex_reg;
    logic                        seen_reg;

    logic                        take;
    logic                        issue_fire;
    logic                        done;
    logic                        advance;
    issue_t                      issue;
    corner_t                     corner;

    logic signed [CORNER_W-1:0]  x2;
    logic signed [CORNER_W-1:0]  y2;
    logic signed [CORNER_W-1:0]  w1;
    logic signed [CORNER_W-1:0]  h1;
    logic signed [CORNER_W-1:0]  left_next;
    logic signed [CORNER_W-1:0]  right_next;
    logic signed [CORNER_W-1:0]  bottom_next;
    logic signed [CORNER_W-1:0]  top_next;
    logic [UV_W:0]               u_sum;
    logic [UV_W:0]               v_sum;
    logic [UV_W-1:0]             u_r_next;
    logic [UV_W-1:0]             v_t_next;
    logic signed [TRIG_W-1:0]    sin_next;
    logic signed [TRIG_W-1:0]    cos_next;
    logic                        start_next;

    sqvb_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .turn (sprite.turn),
        .sin  (sin_next),
        .cos  (cos_next)
    );

    // corners at doubled scale so half sizes stay exact in center mode
    assign x2 = {{(CORNER_W - POS_W - 1){sprite.rect_x[POS_W-1]}}, sprite.rect_x, 1'b0};
    assign y2 = {{(CORNER_W - POS_W - 1){sprite.rect_y[POS_W-1]}}, sprite.rect_y, 1'b0};
    assign w1 = signed'({{(CORNER_W - SIZE_W){1'b0}}, sprite.rect_w});
    assign h1 = signed'({{(CORNER_W - SIZE_W){1'b0}}, sprite.rect_h});

    always_comb
    begin
        if (sprite.op)
        begin
            left_next   = x2 - w1;
            right_next  = x2 + w1;
            bottom_next = y2 - h1;
            top_next    = y2 + h1;
        end
        else
        begin
            left_next   = x2;
            right_next  = x2 + (w1 <<< 1);
            bottom_next = y2;
            top_next    = y2 + (h1 <<< 1);
        end
    end

    // clamp UV far edges at the top of the range
    assign u_sum    = (UV_W + 1)'(sprite.tex_u) + (UV_W + 1)'(sprite.tex_w);
    assign v_sum    = (UV_W + 1)'(sprite.tex_v) + (UV_W + 1)'(sprite.tex_h);
    assign u_r_next = u_sum[UV_W] ? '1 : u_sum[UV_W-1:0];
    assign v_t_next = v_sum[UV_W] ? '1 : v_sum[UV_W-1:0];

    assign start_next = !seen_reg || (sprite.texture_id != prev_tex_reg);

    // hand-off: a new sprite enters as the last vertex of the old one issues
    assign issue_fire   = spr_valid_reg && advance;
    assign done         = issue_fire && (vidx_reg == VIDX_LAST);
    assign sprite_ready = !spr_valid_reg || done;
    assign take         = sprite_valid && sprite_ready;

    always_comb
    begin
        case (vidx_reg)
            VIDX_W'(0): corner = CORNER_TL;
            VIDX_W'(1): corner = CORNER_BL;
            VIDX_W'(2): corner = CORNER_BR;
            VIDX_W'(3): corner = CORNER_BR;
            VIDX_W'(4): corner = CORNER_TR;
            default:    corner = CORNER_TL;
        endcase
    end

    always_comb
    begin
        issue.x           = (corner == CORNER_TL || corner == CORNER_BL) ? left_reg : right_reg;
        issue.y           = (corner == CORNER_TL || corner == CORNER_TR) ? top_reg : bottom_reg;
        issue.u           = (corner == CORNER_TL || corner == CORNER_BL) ? u_l_reg : u_r_reg;
        issue.v           = (corner == CORNER_TL || corner == CORNER_TR) ? v_t_reg : v_b_reg;
        issue.sin         = sin_reg;
        issue.cos         = cos_reg;
        issue.rgba        = rgba_reg;
        issue.tex         = tex_reg;
        issue.group_start = start_reg && (vidx_reg == '0);
        issue.last        = (vidx_reg == VIDX_LAST);
    end

    sqvb_vertex_pipe u_vertex_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue_valid (spr_valid_reg),
        .issue       (issue),
        .advance     (advance),
        .vert_valid  (vert_valid),
        .vert_ready  (vert_ready),
        .vert        (vert)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_valid_reg <= 1'b0;
            vidx_reg      <= '0;
            prev_tex_reg  <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                spr_valid_reg <= 1'b1;
                vidx_reg      <= '0;
                prev_tex_reg  <= sprite.texture_id;
                seen_reg      <= 1'b1;
            end
            else if (done)
            begin
                spr_valid_reg <= 1'b0;
                vidx_reg      <= '0;
            end
            else if (issue_fire)
            begin
                vidx_reg <= vidx_reg + VIDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            top_reg    <= top_next;
            sin_reg    <= sin_next;
            cos_reg    <= cos_next;
            u_l_reg    <= sprite.tex_u;
            u_r_reg    <= u_r_next;
            v_b_reg    <= sprite.tex_v;
            v_t_reg    <= v_t_next;
            rgba_reg   <= sprite.rgba;
            tex_reg    <= sprite.texture_id;
            start_reg  <= start_next;
        end
    end

endmodule

@@ tb/sv/sprite_quad_vertex_batcher_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_quad_vertex_batcher_test
// Drives sprite requests with random gaps and stalls the vertex side at
// random. Compares every vertex request field by field against a local
// rotate-and-saturate predictor that is fed from the accepted sprites.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_batcher_test;
    import sqvb_pkg::*;

    localparam int SINE_DEPTH    = 256;
    localparam int RESET_CYCLES  = 7;
    // cycles with no request accepted on either side before the run is abandoned
    localparam int STALL_LIMIT   = 4000;
    // sprite register, product register, output register, plus margin
    localparam int DRAIN_CYCLES  = 16;

    localparam logic OP_CORNER = 1'b0;
    localparam logic OP_CENTER = 1'b1;

    typedef enum int {CORNER_TL, CORNER_BL, CORNER_BR, CORNER_TR} corner_e;

    // triangle list order of the six vertices
    localparam corner_e QUAD_ORDER [VERTS_PER_QUAD] =
        '{CORNER_TL, CORNER_BL, CORNER_BR, CORNER_BR, CORNER_TR, CORNER_TL};

    logic    clk;
    logic    rst_n;
    logic    sprite_valid;
    logic    sprite_ready;
    sprite_t sprite;
    logic    vert_valid;
    logic    vert_ready;
    vert_t   vert;

    // predictor state
    logic [15:0] sine_quarter [SINE_DEPTH];
    logic [TEX_W-1:0] last_texture;
    logic        seen_sprite;
    vert_t       quad_verts_due [$];

    int          error_count;
    int          stall_cycles;
    int          vert_count;
    bit          idle_en;
    int          ready_hold;

    sprite_quad_vertex_batcher #(
        .SINE_TABLE_DEPTH (SINE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sprite_valid (sprite_valid),
        .sprite_ready (sprite_ready),
        .sprite       (sprite),
        .vert_valid   (vert_valid),
        .vert_ready   (vert_ready),
        .vert         (vert)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Build one quarter-wave entry from the truncated Taylor series in Q30,
    // then round to Q1.15 and clamp below 1.0.
    function automatic logic [15:0] quarter_sine_entry(input int unsigned idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned rounded;
        x    = (64'(idx) * HALF_PI_Q30) / 64'(SINE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int k = 1; k <= 5; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        rounded = (acc + (64'd1 << 14)) >> 15;
        return (rounded > 64'd32767) ? 16'd32767 : rounded[15:0];
    endfunction

    // The quarter point itself reads as exactly 1.0.
    function automatic longint quarter_read(input longint idx);
        if (idx >= SINE_DEPTH)
            return 32768;
        return longint'(sine_quarter[idx]);
    endfunction

    function automatic longint sine_at(input longint phase);
        longint p;
        longint quadrant;
        longint offset;
        p        = phase % (4 * SINE_DEPTH);
        quadrant = p / SINE_DEPTH;
        offset   = p % SINE_DEPTH;
        case (quadrant)
            0:       return quarter_read(offset);
            1:       return quarter_read(SINE_DEPTH - offset);
            2:       return -quarter_read(offset);
            default: return -quarter_read(SINE_DEPTH - offset);
        endcase
    endfunction

    // Drop 16 fraction bits rounding half up, then clamp to signed Q16.8.
    function automatic logic [POS_W-1:0] round_clamp(input longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 64'sd8388607)
            r = 64'sd8388607;
        if (r < -64'sd8388608)
            r = -64'sd8388608;
        return r[POS_W-1:0];
    endfunction

    function automatic logic [UV_W-1:0] uv_add_clamp(input logic [UV_W-1:0] a,
                                                     input logic [UV_W-1:0] b);
        logic [UV_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[UV_W] ? {UV_W{1'b1}} : sum[UV_W-1:0];
    endfunction

    // Form the corners at doubled scale, rotate about the origin and queue
    // the six vertices that the sprite must produce.
    task automatic rotate_quad(input sprite_t s);
        longint  rx;
        longint  ry;
        longint  w;
        longint  h;
        longint  left;
        longint  right;
        longint  bottom;
        longint  top;
        longint  phase;
        longint  sin_v;
        longint  cos_v;
        longint  cx [4];
        longint  cy [4];
        logic [UV_W-1:0] cu [4];
        logic [UV_W-1:0] cv [4];
        logic [UV_W-1:0] u_right;
        logic [UV_W-1:0] v_top;
        logic    new_group;
        corner_e n;
        vert_t   e;
        rx = longint'(s.rect_x);
        ry = longint'(s.rect_y);
        w  = longint'(s.rect_w);
        h  = longint'(s.rect_h);
        if (s.op == OP_CENTER)
        begin
            left   = 2 * rx - w;
            right  = 2 * rx + w;
            bottom = 2 * ry - h;
            top    = 2 * ry + h;
        end
        else
        begin
            left   = 2 * rx;
            right  = 2 * rx + 2 * w;
            bottom = 2 * ry;
            top    = 2 * ry + 2 * h;
        end
        u_right = uv_add_clamp(s.tex_u, s.tex_w);
        v_top   = uv_add_clamp(s.tex_v, s.tex_h);

        cx[CORNER_TL] = left;  cy[CORNER_TL] = top;
        cu[CORNER_TL] = s.tex_u; cv[CORNER_TL] = v_top;
        cx[CORNER_BL] = left;  cy[CORNER_BL] = bottom;
        cu[CORNER_BL] = s.tex_u; cv[CORNER_BL] = s.tex_v;
        cx[CORNER_BR] = right; cy[CORNER_BR] = bottom;
        cu[CORNER_BR] = u_right; cv[CORNER_BR] = s.tex_v;
        cx[CORNER_TR] = right; cy[CORNER_TR] = top;
        cu[CORNER_TR] = u_right; cv[CORNER_TR] = v_top;

        phase = (longint'(s.turn) * 4 * SINE_DEPTH) >> 16;
        sin_v = sine_at(phase);
        cos_v = sine_at(phase + SINE_DEPTH);

        new_group = !seen_sprite || (s.texture_id != last_texture);

        for (int k = 0; k < VERTS_PER_QUAD; k++)
        begin
            n              = QUAD_ORDER[k];
            e.vert_x       = round_clamp(cx[n] * cos_v - cy[n] * sin_v);
            e.vert_y       = round_clamp(cx[n] * sin_v + cy[n] * cos_v);
            e.vert_u       = cu[n];
            e.vert_v       = cv[n];
            e.vert_rgba    = s.rgba;
            e.vert_texture = s.texture_id;
            e.group_start  = (k == 0) && new_group;
            e.last         = (k == VERTS_PER_QUAD - 1);
            quad_verts_due.insert(quad_verts_due.size(), e);
        end
        last_texture = s.texture_id;
        seen_sprite  = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("MISMATCH vertex %0d: %s", vert_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic compare_vertex(input vert_t got, input vert_t want);
        check_field("vert_x",       32'(got.vert_x),       32'(want.vert_x));
        check_field("vert_y",       32'(got.vert_y),       32'(want.vert_y));
        check_field("vert_u",       32'(got.vert_u),       32'(want.vert_u));
        check_field("vert_v",       32'(got.vert_v),       32'(want.vert_v));
        check_field("vert_rgba",    got.vert_rgba,         want.vert_rgba);
        check_field("vert_texture", 32'(got.vert_texture), 32'(want.vert_texture));
        check_field("group_start",  32'(got.group_start),  32'(want.group_start));
        check_field("last",         32'(got.last),         32'(want.last));
    endtask

    // Check vertex requests first: a sprite accepted on this edge cannot
    // have produced a vertex yet, so the order inside the edge is safe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (vert_valid && vert_ready)
            begin
                if (quad_verts_due.size() == 0)
                    report_mismatch($sformatf("unexpected vertex x=%0h y=%0h",
                                              vert.vert_x, vert.vert_y));
                else
                    compare_vertex(vert, quad_verts_due.pop_front());
                vert_count++;
            end
            if (sprite_valid && sprite_ready)
                rotate_quad(sprite);
            if ((vert_valid && vert_ready) || (sprite_valid && sprite_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Abandon the run when neither side has moved for too long.
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Idle and stall generation
    // ------------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Vertex side: hold ready low for random stretches while idling is on.
    always @(posedge clk)
    begin
        if (!idle_en)
        begin
            vert_ready <= 1'b1;
            ready_hold = 0;
        end
        else if (ready_hold > 0)
        begin
            vert_ready <= 1'b0;
            ready_hold--;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            ready_hold = random_gap();
            vert_ready <= (ready_hold == 0);
            if (ready_hold > 0)
                ready_hold--;
        end
        else
        begin
            vert_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Offer one sprite request and hold it until accepted. Valid is lowered
    // only when a gap is taken, so it is never dropped and raised in one step.
    task automatic send_sprite(input sprite_t s);
        int gap;
        gap = idle_en ? random_gap() : 0;
        if (gap > 0)
        begin
            sprite_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sprite_valid <= 1'b1;
        sprite       <= s;
        do
            @(posedge clk);
        while (sprite_ready !== 1'b1);
    endtask

    function automatic sprite_t sprite_of(input logic op,
                                          input logic [POS_W-1:0] x,
                                          input logic [POS_W-1:0] y,
                                          input logic [SIZE_W-1:0] w,
                                          input logic [SIZE_W-1:0] h,
                                          input logic [UV_W-1:0] u,
                                          input logic [UV_W-1:0] v,
                                          input logic [UV_W-1:0] tw,
                                          input logic [UV_W-1:0] th,
                                          input logic [ANG_W-1:0] turn,
                                          input logic [TEX_W-1:0] tex,
                                          input logic [RGBA_W-1:0] rgba);
        sprite_t s;
        s.op         = op;
        s.rect_x     = x;
        s.rect_y     = y;
        s.rect_w     = w;
        s.rect_h     = h;
        s.tex_u      = u;
        s.tex_v      = v;
        s.tex_w      = tw;
        s.tex_h      = th;
        s.turn       = turn;
        s.texture_id = tex;
        s.rgba       = rgba;
        return s;
    endfunction

    function automatic logic [POS_W-1:0] random_pos();
        int near;
        near = $urandom_range(0, 4095) - 2048;
        case ($urandom_range(0, 9))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2, 3:    return near[POS_W-1:0];
            default: return POS_W'($urandom());
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return {SIZE_W{1'b1}};
            2, 3, 4:    return SIZE_W'($urandom_range(0, 4095));
            default:    return SIZE_W'($urandom());
        endcase
    endfunction

    function automatic logic [UV_W-1:0] random_uv();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return {UV_W{1'b1}};
            default: return UV_W'($urandom());
        endcase
    endfunction

    // First sprite after reset carries texture 0, which matches the reset
    // value of the previous texture: it must still open a group.
    task automatic test_texture_groups();
        send_sprite(sprite_of(OP_CORNER, 24'h000100, 24'h000100, 23'h000800,
                              23'h000800, 16'h0000, 16'h0000, 16'h4000, 16'h4000,
                              16'h0000, 16'h0000, 32'h11223344));
        send_sprite(sprite_of(OP_CORNER, 24'h000200, 24'h000200, 23'h000800,
                              23'h000800, 16'h0000, 16'h0000, 16'h4000, 16'h4000,
                              16'h0000, 16'h0000, 32'h55667788));
        send_sprite(sprite_of(OP_CENTER, 24'h000300, 24'hFFFD00, 23'h000400,
                              23'h000400, 16'h1000, 16'h1000, 16'h1000, 16'h1000,
                              16'h0000, 16'h0005, 32'h99AABBCC));
        send_sprite(sprite_of(OP_CENTER, 24'h000300, 24'hFFFD00, 23'h000400,
                              23'h000400, 16'h1000, 16'h1000, 16'h1000, 16'h1000,
                              16'h0000, 16'h0005, 32'hDDEEFF00));
        send_sprite(sprite_of(OP_CORNER, 24'h000000, 24'h000000, 23'h000100,
                              23'h000100, 16'h0000, 16'h0000, 16'h0100, 16'h0100,
                              16'h0000, 16'h0000, 32'h01020304));
    endtask

    task automatic test_corner_modes();
        send_sprite(sprite_of(OP_CORNER, 24'h000100, 24'h000200, 23'h000400,
                              23'h000300, 16'h0800, 16'h0400, 16'h2000, 16'h1000,
                              16'h0000, 16'h0001, 32'hCAFE0001));
        send_sprite(sprite_of(OP_CENTER, 24'h000100, 24'h000200, 23'h000400,
                              23'h000300, 16'h0800, 16'h0400, 16'h2000, 16'h1000,
                              16'h0000, 16'h0001, 32'hCAFE0002));
    endtask

    task automatic test_field_extremes();
        send_sprite(sprite_of(OP_CENTER, 24'h800000, 24'h800000, 23'h7FFFFF,
                              23'h7FFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                              16'h0000, 16'hFFFF, 32'h00000000));
        send_sprite(sprite_of(OP_CORNER, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF,
                              23'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'h0000, 32'hFFFFFFFF));
        send_sprite(sprite_of(OP_CENTER, 24'h000000, 24'h000000, 23'h7FFFFF,
                              23'h7FFFFF, 16'h0000, 16'h0000, 16'h8000, 16'h8000,
                              16'h2000, 16'h0ABC, 32'h12345678));
    endtask

    // Exact quarter turns, the last table step before a quarter, and angles
    // that truncate to the neighboring phase.
    task automatic test_quarter_turns();
        logic [ANG_W-1:0] turns [6];
        turns = '{16'h4000, 16'h8000, 16'hC000, 16'h3FC0, 16'h003F, 16'h0040};
        foreach (turns[i])
            send_sprite(sprite_of(OP_CORNER, 24'h001000, 24'hFFF800, 23'h002000,
                                  23'h001000, 16'h0100, 16'h0200, 16'h0300, 16'h0400,
                                  turns[i], 16'h0007, 32'hA5A5A5A5));
    endtask

    task automatic test_uv_saturation();
        send_sprite(sprite_of(OP_CORNER, 24'h000000, 24'h000000, 23'h000100,
                              23'h000100, 16'hF000, 16'h8000, 16'h2000, 16'h8000,
                              16'h0000, 16'h0007, 32'h0F0F0F0F));
        send_sprite(sprite_of(OP_CENTER, 24'h000000, 24'h000000, 23'h000100,
                              23'h000100, 16'hFFFF, 16'h7FFF, 16'h0001, 16'h8000,
                              16'h1000, 16'h0007, 32'hF0F0F0F0));
    endtask

    task automatic test_position_saturation();
        send_sprite(sprite_of(OP_CORNER, 24'h7FFF00, 24'h7FFF00, 23'h7FFFFF,
                              23'h7FFFFF, 16'h0000, 16'h0000, 16'h1000, 16'h1000,
                              16'h0000, 16'h0008, 32'h00FF00FF));
        send_sprite(sprite_of(OP_CENTER, 24'h400000, 24'hC00000, 23'h7FFFFF,
                              23'h7FFFFF, 16'h0000, 16'h0000, 16'h1000, 16'h1000,
                              16'h2000, 16'h0008, 32'hFF00FF00));
    endtask

    task automatic test_zero_size();
        send_sprite(sprite_of(OP_CENTER, 24'h001234, 24'hFEDCBA, 23'h000000,
                              23'h000000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                              16'h1234, 16'h0009, 32'h13579BDF));
        send_sprite(sprite_of(OP_CORNER, 24'h001234, 24'hFEDCBA, 23'h000000,
                              23'h000800, 16'h0400, 16'h0400, 16'h0000, 16'h0400,
                              16'h9876, 16'h0009, 32'h2468ACE0));
    endtask

    // Random sprites. Textures mostly come from a small set so that groups
    // both continue and change; the rest covers the whole id range.
    task automatic test_random_sprites(input int count);
        sprite_t s;
        for (int i = 0; i < count; i++)
        begin
            s.op     = 1'($urandom_range(0, 1));
            s.rect_x = random_pos();
            s.rect_y = random_pos();
            s.rect_w = random_size();
            s.rect_h = random_size();
            s.tex_u  = random_uv();
            s.tex_v  = random_uv();
            s.tex_w  = random_uv();
            s.tex_h  = random_uv();
            if ($urandom_range(0, 4) == 0)
                s.turn = ANG_W'($urandom_range(0, 3) << 14);
            else
                s.turn = ANG_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 9) < 7)
                s.texture_id = TEX_W'($urandom_range(0, 3));
            else
                s.texture_id = TEX_W'($urandom_range(0, 65535));
            s.rgba = $urandom();
            send_sprite(s);
        end
    endtask

    // Run with no gaps on either side to keep the pipe full.
    task automatic test_back_to_back(input int count);
        idle_en = 1'b0;
        test_random_sprites(count);
        idle_en = 1'b1;
    endtask

    initial
    begin
        error_count  = 0;
        stall_cycles = 0;
        vert_count   = 0;
        ready_hold   = 0;
        idle_en      = 1'b1;
        last_texture = '0;
        seen_sprite  = 1'b0;
        for (int i = 0; i < SINE_DEPTH; i++)
            sine_quarter[i] = quarter_sine_entry(i);

        rst_n        <= 1'b0;
        sprite_valid <= 1'b0;
        sprite       <= '0;
        vert_ready   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_texture_groups();
        test_corner_modes();
        test_field_extremes();
        test_quarter_turns();
        test_uv_saturation();
        test_position_saturation();
        test_zero_size();
        test_random_sprites(150);
        test_back_to_back(60);
        test_random_sprites(150);

        sprite_valid <= 1'b0;
        while (quad_verts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (quad_verts_due.size() != 0)
            report_mismatch($sformatf("%0d vertices never arrived",
                                      quad_verts_due.size()));

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
